>>> rtl/core/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, constants and controller/datapath interface structs for the
// sorted symbol set.
// ----------------------------------------------------------------------------
`default_nettype none

package sss_pkg;

   localparam int CAPACITY = 64;
   localparam int CNT_W    = 7;
   localparam int SYM_W    = 7;
   localparam int IDX_W    = $clog2(CAPACITY);

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [SYM_W-1:0] sym_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [1:0]       op_type;

   localparam op_type CMD_INSERT = 2'd0;
   localparam op_type CMD_REMOVE = 2'd1;

   typedef enum logic [1:0] {
      RD_IDX   = 2'd0,
      RD_BELOW = 2'd1,
      RD_ABOVE = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       capture;
      logic       set_pos;
      logic       pos_hit;
      logic       idx_inc;
      logic       idx_dec;
      logic       idx_to_occ;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_shift;
      logic       wr_sym;
      logic       occ_dec;
      logic       set_ovf;
      logic       load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic idx_lt_occ;
      logic rd_lt_sym;
      logic rd_eq_sym;
      logic is_insert;
      logic is_remove;
      logic full;
      logic present;
      logic idx_gt_pos;
      logic idx_p1_lt_occ;
      logic rsp_busy;
   } ctrl_status_type;

endpackage

`default_nettype wire

>>> rtl/core/sss_datapath.sv
// ----------------------------------------------------------------------------
// sss_datapath
// Member memory, scan/shift index, occupancy count, transaction registers and
// the registered response.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_datapath (
   input  wire                       clock,
   input  wire                       reset,
   input  wire sss_pkg::op_type      req_command,
   input  wire sss_pkg::sym_type     req_symbol,
   input  wire                       rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_was_present,
   output logic                      rsp_changed,
   output logic                      rsp_overflow,
   output sss_pkg::cnt_type          rsp_member_count,
   input  wire sss_pkg::ctrl_cmd_type    cmd,
   output sss_pkg::ctrl_status_type      status
);
   import sss_pkg::*;

   sym_type mem [CAPACITY];

   op_type  op_ff;
   sym_type sym_ff;
   sym_type rd_data_ff;
   cnt_type idx_ff, idx_in;
   cnt_type pos_ff;
   cnt_type occ_ff, occ_in;
   logic    present_ff;
   logic    changed_ff;
   logic    ovf_ff;
   logic    rsp_valid_ff;
   logic    rsp_present_ff;
   logic    rsp_changed_ff;
   logic    rsp_ovf_ff;
   cnt_type rsp_count_ff;

   cnt_type idx_m1;
   cnt_type idx_p1;
   idx_type rd_addr;
   idx_type wr_addr;
   sym_type wr_data;

   assign idx_m1 = idx_ff - cnt_type'(1);
   assign idx_p1 = idx_ff + cnt_type'(1);

   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:   rd_addr = idx_ff[IDX_W-1:0];
         RD_BELOW: rd_addr = idx_m1[IDX_W-1:0];
         RD_ABOVE: rd_addr = idx_p1[IDX_W-1:0];
         default:  rd_addr = idx_ff[IDX_W-1:0];
      endcase
   end

   assign wr_addr = cmd.wr_sym ? pos_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.wr_sym ? sym_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cmd.wr_shift || cmd.wr_sym) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.capture) begin
         idx_in = '0;
      end else if (cmd.idx_to_occ) begin
         idx_in = occ_ff;
      end else if (cmd.idx_inc) begin
         idx_in = idx_p1;
      end else if (cmd.idx_dec) begin
         idx_in = idx_m1;
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.wr_sym) begin
         occ_in = occ_ff + cnt_type'(1);
      end else if (cmd.occ_dec) begin
         occ_in = occ_ff - cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.capture) begin
         op_ff  <= req_command;
         sym_ff <= req_symbol;
      end
      if (cmd.set_pos) begin
         pos_ff <= idx_ff;
      end
      if (cmd.load_rsp) begin
         rsp_present_ff <= present_ff;
         rsp_changed_ff <= changed_ff;
         rsp_ovf_ff     <= ovf_ff;
         rsp_count_ff   <= occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         present_ff   <= 1'b0;
         changed_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (cmd.capture) begin
            present_ff <= 1'b0;
            changed_ff <= 1'b0;
            ovf_ff     <= 1'b0;
         end else begin
            if (cmd.set_pos) begin
               present_ff <= cmd.pos_hit;
            end
            if (cmd.wr_sym || cmd.occ_dec) begin
               changed_ff <= 1'b1;
            end
            if (cmd.set_ovf) begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.idx_lt_occ    = idx_ff < occ_ff;
   assign status.rd_lt_sym     = rd_data_ff < sym_ff;
   assign status.rd_eq_sym     = rd_data_ff == sym_ff;
   assign status.is_insert     = op_ff == CMD_INSERT;
   assign status.is_remove     = op_ff == CMD_REMOVE;
   assign status.full          = occ_ff >= cnt_type'(CAPACITY);
   assign status.present       = present_ff;
   assign status.idx_gt_pos    = idx_ff > pos_ff;
   assign status.idx_p1_lt_occ = idx_p1 < occ_ff;
   assign status.rsp_busy      = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_present  = rsp_present_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_overflow     = rsp_ovf_ff;
   assign rsp_member_count = rsp_count_ff;

endmodule

`default_nettype wire

>>> rtl/core/sss_controller.sv
// ----------------------------------------------------------------------------
// sss_controller
// Sequencer: linear scan for the sorted slot, then, when the set changes, a
// read/write shift loop to open or close a gap, then response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sss_controller (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire sss_pkg::ctrl_status_type status,
   output sss_pkg::ctrl_cmd_type         cmd
);
   import sss_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN_RD  = 9'b000000010,
      S_SCAN_CMP = 9'b000000100,
      S_DECIDE   = 9'b000001000,
      S_UP_CHK   = 9'b000010000,
      S_UP_WR    = 9'b000100000,
      S_DN_CHK   = 9'b001000000,
      S_DN_WR    = 9'b010000000,
      S_FINISH   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_IDX;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (status.idx_lt_occ) begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCAN_CMP;
            end else begin
               cmd.set_pos = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_SCAN_CMP: begin
            if (status.rd_lt_sym) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end else begin
               cmd.set_pos = 1'b1;
               cmd.pos_hit = status.rd_eq_sym;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.is_insert && !status.present) begin
               if (status.full) begin
                  cmd.set_ovf = 1'b1;
                  state_in    = S_FINISH;
               end else begin
                  cmd.idx_to_occ = 1'b1;
                  state_in       = S_UP_CHK;
               end
            end else if (status.is_remove && status.present) begin
               state_in = S_DN_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_UP_CHK: begin
            if (status.idx_gt_pos) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_BELOW;
               state_in   = S_UP_WR;
            end else begin
               cmd.wr_sym = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_UP_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_in     = S_UP_CHK;
         end
         S_DN_CHK: begin
            if (status.idx_p1_lt_occ) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ABOVE;
               state_in   = S_DN_WR;
            end else begin
               cmd.occ_dec = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_DN_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_DN_CHK;
         end
         S_FINISH: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

`default_nettype wire

>>> rtl/core/sorted_symbol_set_top.sv
// ----------------------------------------------------------------------------
// sorted_symbol_set_top
// Ordered set of distinct 7-bit symbols: insert, remove and membership query,
// one response transaction per request transaction.
//
//   channel | ports                                    | direction
//   req     | req_valid/req_ready, req_command, req_symbol | in
//   rsp     | rsp_valid/rsp_ready, rsp_was_present,    | out
//           | rsp_changed, rsp_overflow, rsp_member_count |
//
// One request at a time. The wait from the accepting edge to rsp_valid grows
// with the members below the symbol and the members shifted. The member
// memory gives one read and one write per cycle, and that sets the scan and
// the shift.
// Synchronous active-high reset empties the set; member memory is not cleared.
// A new request is taken while the previous response waits in its register.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_symbol_set_top (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire sss_pkg::op_type  req_command,
   input  wire sss_pkg::sym_type req_symbol,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic                  rsp_was_present,
   output logic                  rsp_changed,
   output logic                  rsp_overflow,
   output sss_pkg::cnt_type      rsp_member_count
);
   import sss_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   sss_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sss_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_symbol       (req_symbol),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_was_present  (rsp_was_present),
      .rsp_changed      (rsp_changed),
      .rsp_overflow     (rsp_overflow),
      .rsp_member_count (rsp_member_count),
      .cmd              (cmd),
      .status           (status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_member_count <= cnt_type'(CAPACITY))
      else $error("member count beyond capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         !rsp_changed && !rsp_was_present && rsp_member_count == cnt_type'(CAPACITY))
      else $error("overflow flagged on a set that was not full");

   a_changed_flip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed && !rsp_was_present |-> rsp_member_count != '0)
      else $error("insert left an empty set");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_symbol_set_top. A queue-fed driver offers
// insert, remove and query transactions with random gaps. A scoreboard keeps
// a membership map of the set and predicts every response. The monitor
// stalls at random, with two long hold-offs to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   import sss_pkg::*;

   localparam op_type      CMD_QUERY   = 2'd2;
   localparam op_type      CMD_UNUSED  = 2'd3;
   localparam int          NUM_SYMS    = 1 << SYM_W;
   localparam int          HOLD_CYCLES = 240;
   localparam int          HOLD_AT_A   = 150;
   localparam int          HOLD_AT_B   = 360;
   localparam int          WD_LIMIT    = 3000;
   localparam int          TAIL_CYCLES = 4 * CAPACITY + 16;
   localparam int          MAX_SHOWN   = 10;

   typedef struct {
      op_type      cmd;
      sym_type     sym;
      int unsigned gap;
   } set_cmd_type;

   typedef struct packed {
      logic    was_present;
      logic    changed;
      logic    overflow;
      cnt_type member_count;
   } set_result_type;

   logic    clock;
   logic    reset            = 1'b1;
   logic    req_valid        = 1'b0;
   logic    req_ready;
   op_type  req_command      = CMD_QUERY;
   sym_type req_symbol       = '0;
   logic    rsp_valid;
   logic    rsp_ready        = 1'b0;
   logic    rsp_was_present;
   logic    rsp_changed;
   logic    rsp_overflow;
   cnt_type rsp_member_count;

   set_cmd_type    cmd_backlog[$];
   set_result_type pending_results[$];

   logic [NUM_SYMS-1:0] member_map   = '0;
   int                  member_total = 0;

   int             n_planned   = 0;
   int             n_sent      = 0;
   int             n_rsp       = 0;
   int             n_errors    = 0;
   int             n_changes   = 0;
   int             n_drops     = 0;
   int             n_holds     = 0;
   int             peak_count  = 0;
   int             op_mix[4]   = '{0, 0, 0, 0};
   int unsigned    tx_wait     = 0;
   int unsigned    stall_left  = 0;
   int unsigned    hold_left   = 0;
   int unsigned    rx_burst    = 0;
   int unsigned    idle_cycles = 0;
   set_cmd_type    tx_item;
   set_result_type got_result;
   set_result_type want_result;

   sorted_symbol_set_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_symbol       (req_symbol),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_was_present  (rsp_was_present),
      .rsp_changed      (rsp_changed),
      .rsp_overflow     (rsp_overflow),
      .rsp_member_count (rsp_member_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Membership map is enough: every response field depends only on the
   // members present, not on their order.
   function automatic set_result_type apply_set_command(op_type cmd, sym_type sym);
      set_result_type r;
      r.was_present = member_map[sym];
      r.changed     = 1'b0;
      r.overflow    = 1'b0;
      if (cmd == CMD_INSERT) begin
         if (!member_map[sym]) begin
            if (member_total >= CAPACITY) begin
               r.overflow = 1'b1;
            end else begin
               member_map[sym] = 1'b1;
               member_total++;
               r.changed = 1'b1;
            end
         end
      end else if (cmd == CMD_REMOVE) begin
         if (member_map[sym]) begin
            member_map[sym] = 1'b0;
            member_total--;
            r.changed = 1'b1;
         end
      end
      r.member_count = cnt_type'(member_total);
      return r;
   endfunction

   task automatic log_error(input string msg);
      n_errors++;
      if (n_errors <= MAX_SHOWN)
         $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   task automatic queue_cmd(input op_type cmd, input sym_type sym, input int unsigned gap);
      set_cmd_type c;
      c.cmd = cmd;
      c.sym = sym;
      c.gap = gap;
      cmd_backlog.push_back(c);
      op_mix[cmd]++;
   endtask

   function automatic op_type pick_cmd(int ins_pct, int rem_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ins_pct)
         return CMD_INSERT;
      if (r < ins_pct + rem_pct)
         return CMD_REMOVE;
      return ($urandom_range(0, 7) == 0) ? CMD_UNUSED : CMD_QUERY;
   endfunction

   // First few transactions of each round go back to back.
   function automatic int unsigned pick_gap(int idx);
      return (idx < 20) ? 0 : $urandom_range(0, 3);
   endfunction

   task automatic build_stimulus();
      int base;
      int start;
      // directed: empty set, both extreme symbols, duplicates, absent removes
      queue_cmd(CMD_QUERY,  7'd0,   0);
      queue_cmd(CMD_REMOVE, 7'd0,   0);
      queue_cmd(CMD_INSERT, 7'd0,   0);
      queue_cmd(CMD_INSERT, 7'd127, 0);
      queue_cmd(CMD_INSERT, 7'd0,   0);
      queue_cmd(CMD_QUERY,  7'd0,   1);
      queue_cmd(CMD_QUERY,  7'd127, 0);
      queue_cmd(CMD_UNUSED, 7'd127, 0);
      queue_cmd(CMD_UNUSED, 7'd5,   2);
      queue_cmd(CMD_INSERT, 7'd64,  0);
      queue_cmd(CMD_INSERT, 7'd63,  0);
      queue_cmd(CMD_INSERT, 7'd65,  0);
      queue_cmd(CMD_INSERT, 7'd1,   3);
      queue_cmd(CMD_INSERT, 7'd126, 0);
      queue_cmd(CMD_REMOVE, 7'd64,  0);
      queue_cmd(CMD_REMOVE, 7'd64,  0);
      queue_cmd(CMD_QUERY,  7'd63,  1);
      queue_cmd(CMD_QUERY,  7'd64,  0);
      queue_cmd(CMD_REMOVE, 7'd0,   0);
      queue_cmd(CMD_REMOVE, 7'd127, 0);
      queue_cmd(CMD_INSERT, 7'd127, 0);
      queue_cmd(CMD_INSERT, 7'h55,  0);
      queue_cmd(CMD_INSERT, 7'h2a,  0);
      queue_cmd(CMD_REMOVE, 7'h2a,  0);
      // fill until full, then hammer the full set
      for (int i = 0; i < 120; i++)
         queue_cmd(pick_cmd(85, 5), sym_type'($urandom_range(0, NUM_SYMS - 1)), pick_gap(i));
      for (int i = 0; i < 90; i++)
         queue_cmd(pick_cmd(45, 25), sym_type'($urandom_range(0, NUM_SYMS - 1)), pick_gap(i));
      // sweep every symbol out, emptying the set
      start = $urandom_range(0, NUM_SYMS - 1);
      for (int i = 0; i < NUM_SYMS; i++)
         queue_cmd(CMD_REMOVE, sym_type'((start + i) % NUM_SYMS), pick_gap(i));
      // churn inside narrow windows so hits are frequent
      for (int i = 0; i < 110; i++) begin
         if (i % 22 == 0)
            base = $urandom_range(0, NUM_SYMS - 16);
         queue_cmd(pick_cmd(35, 35), sym_type'(base + $urandom_range(0, 15)), pick_gap(i));
      end
      n_planned = cmd_backlog.size();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            pending_results.push_back(apply_set_command(req_command, req_symbol));
            n_sent++;
         end
         if (!req_valid || req_ready) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               tx_item = cmd_backlog.pop_front();
               req_command <= tx_item.cmd;
               req_symbol  <= tx_item.sym;
               req_valid   <= 1'b1;
               if (cmd_backlog.size() != 0)
                  tx_wait = cmd_backlog[0].gap;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_result.was_present  = rsp_was_present;
            got_result.changed      = rsp_changed;
            got_result.overflow     = rsp_overflow;
            got_result.member_count = rsp_member_count;
            n_rsp++;
            if (pending_results.size() == 0) begin
               log_error($sformatf("response with no transaction outstanding: %p", got_result));
            end else begin
               want_result = pending_results.pop_front();
               if (got_result.was_present !== want_result.was_present ||
                   got_result.changed !== want_result.changed ||
                   got_result.overflow !== want_result.overflow ||
                   got_result.member_count !== want_result.member_count)
                  log_error($sformatf("response %0d: expected %p, got %p",
                                      n_rsp, want_result, got_result));
               if (want_result.changed)
                  n_changes++;
               if (want_result.overflow)
                  n_drops++;
               if (int'(want_result.member_count) > peak_count)
                  peak_count = want_result.member_count;
            end
            if (rx_burst > 0) begin
               rx_burst--;
               stall_left = 0;
            end else begin
               stall_left = $urandom_range(0, 3);
               if ($urandom_range(0, 15) == 0)
                  rx_burst = 24;
            end
            if (n_rsp == HOLD_AT_A || n_rsp == HOLD_AT_B) begin
               hold_left = HOLD_CYCLES;
               n_holds++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("[%0t] ERROR: no transaction for %0d cycles, %0d of %0d sent",
                     $realtime, WD_LIMIT, n_sent, n_planned);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (n_sent < n_planned)
         @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d commands: %0d insert, %0d remove, %0d query, %0d unused code",
               n_planned, op_mix[CMD_INSERT], op_mix[CMD_REMOVE], op_mix[CMD_QUERY],
               op_mix[CMD_UNUSED]);
      $display("%0d set changes, %0d full-set drops, peak %0d members, %0d long hold-offs",
               n_changes, n_drops, peak_count, n_holds);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d errors", n_errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
